// File: hw/rtl/sdmbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdmbc_pkg: shared types and constants
// Widths, status codes and inter-module structs of the segmented block cache.
// ----------------------------------------------------------------------------
package sdmbc_pkg;

	// Sizing
	localparam int MAX_SEGMENTS = 20;
	localparam int MAX_SLOTS    = 1024;
	localparam int BLOCK_BITS   = 9;
	localparam int TAG_W        = 15;
	localparam logic [TAG_W-1:0] TAG_MAX = 15'h7fff;

	// Field widths
	localparam int SEG_SIZE_W = 32;
	localparam int OFFSET_W   = 32;
	localparam int FILE_W     = 5;
	localparam int STATUS_W   = 3;
	localparam int HANDLE_W   = 5;

	// Derived widths
	localparam int SLOT_W      = $clog2(MAX_SLOTS);
	localparam int SC_W        = $clog2(MAX_SLOTS + 1);
	localparam int SEG_IDX_W   = $clog2(MAX_SEGMENTS + 1);
	localparam int BLK_W       = TAG_W + SLOT_W;
	localparam int LIM_W       = BLK_W + BLOCK_BITS;
	localparam int SUM_W       = LIM_W + 1;
	localparam int DIVIDEND_W  = SUM_W - BLOCK_BITS;
	localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);
	localparam int MUL_W       = TAG_W + SC_W;

	// Functions of an input transaction
	localparam logic FUNC_OPEN = 1'b0;
	localparam logic FUNC_FIND = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_MANY      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_HANDLE    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OUT_OF_LIMITS = 3'd4;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [SC_W-1:0]       divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quot;
		logic [SC_W-1:0]       rem;
	} div_rsp_t;

	typedef struct packed {
		logic                 en;
		logic [SEG_IDX_W-1:0] addr;
		logic [LIM_W-1:0]     data;
	} seg_wr_t;

endpackage
`default_nettype wire

// File: hw/rtl/sdmbc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdmbc_if: request and response channels
// Valid/ready channels carrying the request and response transactions.
// ----------------------------------------------------------------------------
interface sdmbc_in_if;
	import sdmbc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  func;
	logic [SEG_SIZE_W-1:0] seg_size;
	logic [FILE_W-1:0]     file_id;
	logic [OFFSET_W-1:0]   offset;
	logic                  write_mark;

	modport source (output valid, func, seg_size, file_id, offset, write_mark,
		input ready);
	modport sink (input valid, func, seg_size, file_id, offset, write_mark,
		output ready);
endinterface

interface sdmbc_out_if;
	import sdmbc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [HANDLE_W-1:0]   handle;
	logic [SLOT_W-1:0]     slot;
	logic [BLOCK_BITS-1:0] byte_offset;
	logic                  writeback;
	logic [BLK_W-1:0]      writeback_block;
	logic                  fill;
	logic [BLK_W-1:0]      fill_block;

	modport source (output valid, status, handle, slot, byte_offset, writeback,
		writeback_block, fill, fill_block, input ready);
	modport sink (input valid, status, handle, slot, byte_offset, writeback,
		writeback_block, fill, fill_block, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sdmbc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdmbc_div: shared restoring divider
// One quotient bit per cycle; block number by slot count.
// ----------------------------------------------------------------------------
module sdmbc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  sdmbc_pkg::div_req_t req,
	output sdmbc_pkg::div_rsp_t rsp
);
	import sdmbc_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [SC_W-1:0]       rem_q;
	logic [SC_W-1:0]       dvs_q;

	logic [SC_W:0]   trial;
	logic [SC_W:0]   diff;
	logic            ge;
	logic [SC_W-1:0] nrem;

	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};
	assign nrem  = ge ? diff[SC_W-1:0] : trial[SC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= nrem;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

// File: hw/rtl/sdmbc_seg_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdmbc_seg_table: segment end-address table
// Cumulative segment ends; entry 0 always reads as zero.
// ----------------------------------------------------------------------------
module sdmbc_seg_table (
	input  logic                            clk,
	input  logic [sdmbc_pkg::SEG_IDX_W-1:0] rd_addr,
	output logic [sdmbc_pkg::LIM_W-1:0]     rd_data,
	input  sdmbc_pkg::seg_wr_t              wr
);
	import sdmbc_pkg::*;

	logic [LIM_W-1:0] lim_mem [MAX_SEGMENTS+1];
	logic [LIM_W-1:0] rdata_q;
	logic             zero_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			lim_mem[wr.addr] <= wr.data;
		end
		rdata_q <= lim_mem[rd_addr];
		zero_q  <= (rd_addr == '0);
	end

	// entry 0 is never written: it is the base of the first segment
	assign rd_data = zero_q ? '0 : rdata_q;

endmodule
`default_nettype wire

// File: hw/rtl/segmented_direct_mapped_block_cache_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segmented_direct_mapped_block_cache_unit: block cache directory
// Segment table plus direct-mapped write-back tag store with miss reporting.
// ----------------------------------------------------------------------------
// Throughput: one transaction at a time, next one taken the cycle after the
//   response loads; the 26-step shared divider sets it.
// Reset: arst_n clears control; then a clearing pass zeroes the tag store
//   (tag 0, clean) with req.ready low; slot_count comes up at 1024.
// ----------------------------------------------------------------------------
module segmented_direct_mapped_block_cache_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [sdmbc_pkg::SC_W-1:0] cfg_wdata,
	sdmbc_in_if.sink                   req,
	sdmbc_out_if.source                rsp
);
	import sdmbc_pkg::*;

	// Sequencer states
	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_LIM0     = 4'd2;
	localparam logic [3:0] S_LIM1     = 4'd3;
	localparam logic [3:0] S_DIV_GO   = 4'd4;
	localparam logic [3:0] S_DIV_WAIT = 4'd5;
	localparam logic [3:0] S_TAG_RD   = 4'd6;
	localparam logic [3:0] S_TAG_CHK  = 4'd7;
	localparam logic [3:0] S_MUL      = 4'd8;
	localparam logic [3:0] S_DONE     = 4'd9;

	// Control state
	logic [3:0]           state_q;
	logic [SLOT_W-1:0]    clr_q;
	logic [SEG_IDX_W-1:0] seg_cnt_q;
	logic [SC_W-1:0]      sc_q;
	logic                 out_valid_q;

	// Latched request
	logic                  func_q;
	logic [SEG_SIZE_W-1:0] seg_size_q;
	logic [FILE_W-1:0]     file_id_q;
	logic [OFFSET_W-1:0]   offset_q;
	logic                  write_q;

	// Working registers
	logic [LIM_W-1:0]  lim_a_q;
	logic [SUM_W-1:0]  sum_q;      // segment end (open) or global address (find)
	logic [SLOT_W-1:0] slot_q;
	logic [TAG_W-1:0]  tag_new_q;
	logic [TAG_W-1:0]  old_tag_q;
	logic [TAG_W:0]    tag_rd_q;   // {dirty, tag}

	// Response under construction
	logic [STATUS_W-1:0]   res_status;
	logic [HANDLE_W-1:0]   res_handle;
	logic [SLOT_W-1:0]     res_slot;
	logic [BLOCK_BITS-1:0] res_byte_off;
	logic                  res_wb;
	logic [BLK_W-1:0]      res_wb_block;
	logic                  res_fill;
	logic [BLK_W-1:0]      res_fill_block;

	// Output register
	logic [STATUS_W-1:0]   out_status_q;
	logic [HANDLE_W-1:0]   out_handle_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic [BLOCK_BITS-1:0] out_byte_off_q;
	logic                  out_wb_q;
	logic [BLK_W-1:0]      out_wb_block_q;
	logic                  out_fill_q;
	logic [BLK_W-1:0]      out_fill_block_q;

	// Tag store: one entry per slot, {dirty, tag}
	logic [TAG_W:0] tag_mem [MAX_SLOTS];

	logic [SC_W-1:0]      cfg_slots;
	logic [SEG_IDX_W-1:0] seg_rd_addr;
	logic [LIM_W-1:0]     seg_rd_data;
	seg_wr_t              seg_wr;
	div_req_t             div_req;
	div_rsp_t             div_rsp;
	logic                 accept;
	logic                 open_full;
	logic                 find_bad;
	logic [SUM_W-1:0]     find_sum;
	logic                 out_of_lim;
	logic                 tag_ovf;
	logic                 out_load;
	logic [TAG_W-1:0]     old_tag;
	logic                 old_dirty;
	logic                 miss;
	logic                 new_dirty;
	logic                 tag_we;
	logic [SLOT_W-1:0]    tag_waddr;
	logic [TAG_W:0]       tag_wdata;
	logic [MUL_W-1:0]     wb_prod;

	// Slot count clamp: 0 reads as 1, anything above the store size saturates
	assign cfg_slots = (cfg_wdata == '0) ? SC_W'(1) :
		(cfg_wdata > SC_W'(MAX_SLOTS)) ? SC_W'(MAX_SLOTS) : cfg_wdata;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign open_full = (seg_cnt_q >= SEG_IDX_W'(MAX_SEGMENTS));
	assign find_bad  = (SEG_IDX_W'(req.file_id) >= seg_cnt_q);

	// Segment table: base of the addressed (or next) segment, then its end
	always_comb begin
		if (state_q == S_IDLE) begin
			seg_rd_addr = (req.func == FUNC_OPEN) ? seg_cnt_q : SEG_IDX_W'(req.file_id);
		end else begin
			seg_rd_addr = SEG_IDX_W'(file_id_q) + SEG_IDX_W'(1);
		end
	end

	assign find_sum   = SUM_W'(lim_a_q) + SUM_W'(offset_q);
	assign out_of_lim = (find_sum >= SUM_W'(seg_rd_data));

	// Shared divider splits block number into tag (quotient) and slot (remainder)
	assign div_req.start    = (state_q == S_DIV_GO);
	assign div_req.dividend = sum_q[SUM_W-1:BLOCK_BITS];
	assign div_req.divisor  = sc_q;
	assign tag_ovf          = (div_rsp.quot > DIVIDEND_W'(TAG_MAX));

	assign seg_wr.en   = (state_q == S_DIV_WAIT) && div_rsp.done && !tag_ovf &&
		(func_q == FUNC_OPEN);
	assign seg_wr.addr = seg_cnt_q + SEG_IDX_W'(1);
	assign seg_wr.data = sum_q[LIM_W-1:0];

	sdmbc_seg_table u_seg_table (
		.clk     (clk),
		.rd_addr (seg_rd_addr),
		.rd_data (seg_rd_data),
		.wr      (seg_wr)
	);

	sdmbc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Tag lookup: a miss installs the new tag clean; a write marks it dirty
	assign old_tag   = tag_rd_q[TAG_W-1:0];
	assign old_dirty = tag_rd_q[TAG_W];
	assign miss      = (old_tag != tag_new_q);
	assign new_dirty = write_q || (!miss && old_dirty);

	assign tag_we    = (state_q == S_CLEAR) || (state_q == S_TAG_CHK);
	assign tag_waddr = (state_q == S_CLEAR) ? clr_q : slot_q;
	assign tag_wdata = (state_q == S_CLEAR) ? '0 : {new_dirty, tag_new_q};

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_waddr] <= tag_wdata;
		end
		tag_rd_q <= tag_mem[slot_q];
	end

	// Victim block number: old tag under the current slot count
	assign wb_prod = MUL_W'(old_tag_q) * MUL_W'(sc_q) + MUL_W'(slot_q);

	assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			seg_cnt_q   <= '0;
			sc_q        <= SC_W'(MAX_SLOTS);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				sc_q <= cfg_slots;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == SLOT_W'(MAX_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						if (req.func == FUNC_OPEN) begin
							state_q <= open_full ? S_DONE : S_LIM0;
						end else begin
							state_q <= find_bad ? S_DONE : S_LIM0;
						end
					end
				end
				S_LIM0: begin
					state_q <= (func_q == FUNC_OPEN) ? S_DIV_GO : S_LIM1;
				end
				S_LIM1: begin
					state_q <= out_of_lim ? S_DONE : S_DIV_GO;
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						if (tag_ovf) begin
							state_q <= S_DONE;
						end else if (func_q == FUNC_OPEN) begin
							seg_cnt_q <= seg_cnt_q + SEG_IDX_W'(1);
							state_q   <= S_DONE;
						end else begin
							state_q <= S_TAG_RD;
						end
					end
				end
				S_TAG_RD: begin
					state_q <= S_TAG_CHK;
				end
				S_TAG_CHK: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					func_q         <= req.func;
					seg_size_q     <= req.seg_size;
					file_id_q      <= req.file_id;
					offset_q       <= req.offset;
					write_q        <= req.write_mark;
					res_handle     <= '0;
					res_slot       <= '0;
					res_byte_off   <= '0;
					res_wb         <= 1'b0;
					res_wb_block   <= '0;
					res_fill       <= 1'b0;
					res_fill_block <= '0;
					if (req.func == FUNC_OPEN && open_full) begin
						res_status <= ST_TOO_MANY;
					end else if (req.func == FUNC_FIND && find_bad) begin
						res_status <= ST_BAD_HANDLE;
					end else begin
						res_status <= ST_OK;
					end
				end
			end
			S_LIM0: begin
				lim_a_q <= seg_rd_data;
				sum_q   <= SUM_W'(seg_rd_data) + SUM_W'(seg_size_q);
			end
			S_LIM1: begin
				sum_q <= find_sum;
				if (out_of_lim) begin
					res_status <= ST_OUT_OF_LIMITS;
				end
			end
			S_DIV_WAIT: begin
				if (div_rsp.done) begin
					if (tag_ovf) begin
						res_status <= ST_TOO_LARGE;
					end else if (func_q == FUNC_OPEN) begin
						res_handle <= HANDLE_W'(seg_cnt_q);
					end else begin
						slot_q       <= div_rsp.rem[SLOT_W-1:0];
						tag_new_q    <= div_rsp.quot[TAG_W-1:0];
						res_byte_off <= sum_q[BLOCK_BITS-1:0];
					end
				end
			end
			S_TAG_CHK: begin
				old_tag_q      <= old_tag;
				res_wb         <= miss && old_dirty;
				res_fill       <= miss;
				res_fill_block <= miss ? sum_q[BLOCK_BITS +: BLK_W] : '0;
			end
			S_MUL: begin
				res_slot     <= slot_q;
				res_wb_block <= res_wb ? wb_prod[BLK_W-1:0] : '0;
			end
			S_DONE: begin
				if (out_load) begin
					out_status_q     <= res_status;
					out_handle_q     <= res_handle;
					out_slot_q       <= res_slot;
					out_byte_off_q   <= res_byte_off;
					out_wb_q         <= res_wb;
					out_wb_block_q   <= res_wb_block;
					out_fill_q       <= res_fill;
					out_fill_block_q <= res_fill_block;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.handle          = out_handle_q;
	assign rsp.slot            = out_slot_q;
	assign rsp.byte_offset     = out_byte_off_q;
	assign rsp.writeback       = out_wb_q;
	assign rsp.writeback_block = out_wb_block_q;
	assign rsp.fill            = out_fill_q;
	assign rsp.fill_block      = out_fill_block_q;

`ifndef ASSERT_OFF
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV_WAIT))
		else $error("divider finished outside the wait state");

	a_seg_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seg_cnt_q <= SEG_IDX_W'(MAX_SEGMENTS))
		else $error("segment count past table size");

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAG_CHK) |-> (SC_W'(slot_q) < sc_q))
		else $error("slot index not below slot count");

	a_resp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("response raised outside the done state");
`endif

endmodule
`default_nettype wire

// File: verif/segmented_direct_mapped_block_cache_unit_test.sv
// ----------------------------------------------------------------------------
// segmented_direct_mapped_block_cache_unit_test: block cache directory bench
// Sends open and find transactions through the request channel under a range
// of slot counts and checks every response, field by field, against a
// behavioral directory kept alongside the design.
// ----------------------------------------------------------------------------
module segmented_direct_mapped_block_cache_unit_test;
	import sdmbc_pkg::*;

	// No transaction on either channel for this many cycles ends the run.
	// Covers the tag clearing pass after reset plus the longest find latency,
	// a full request gap and response stalls, several times over.
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	// Cycles let pass after the last response before the verdict.
	localparam int unsigned SETTLE_CYCLES = 40;
	// Cycles between the last response and a slot count write.
	localparam int unsigned CFG_GUARD = 4;
	// Number of recently found addresses kept for re-use (hits, conflicts).
	localparam int unsigned RECENT_DEPTH = 16;

	typedef struct packed {
		logic                  func;
		logic [SEG_SIZE_W-1:0] seg_size;
		logic [FILE_W-1:0]     file_id;
		logic [OFFSET_W-1:0]   offset;
		logic                  write_mark;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [HANDLE_W-1:0]   handle;
		logic [SLOT_W-1:0]     slot;
		logic [BLOCK_BITS-1:0] byte_offset;
		logic                  writeback;
		logic [BLK_W-1:0]      writeback_block;
		logic                  fill;
		logic [BLK_W-1:0]      fill_block;
	} reply_t;

	typedef struct {
		logic [FILE_W-1:0]   file_id;
		logic [OFFSET_W-1:0] offset;
	} byte_ref_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [SC_W-1:0]  cfg_wdata;

	sdmbc_in_if  req_ch ();
	sdmbc_out_if rsp_ch ();

	segmented_direct_mapped_block_cache_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// ------------------------------------------------------------------------
	// Shadow directory: segment end addresses, tag store and slot count.
	// Segment i spans [seg_end[i], seg_end[i+1]).
	// ------------------------------------------------------------------------
	bit [63:0]       seg_end [0:MAX_SEGMENTS];
	int unsigned     seg_total;
	bit [TAG_W-1:0]  tag_of [0:MAX_SLOTS-1];
	bit              dirty_of [0:MAX_SLOTS-1];
	int unsigned     slots_in_use;

	reply_t          awaited_replies [$];
	byte_ref_t       recent_finds [$];

	// When set, neither side inserts idle cycles.
	bit              steady_flow;

	int unsigned     n_errors;
	int unsigned     n_opens;
	int unsigned     n_finds;
	int unsigned     n_rejects;
	int unsigned     n_fills;
	int unsigned     n_writebacks;
	int unsigned     n_checked;
	int unsigned     n_cfg_writes;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		n_errors++;
	endtask

	// Clamp as the register does: zero means one slot, anything above the
	// store size means the whole store.
	function automatic void apply_slot_count(input logic [SC_W-1:0] v);
		if (v == '0)
			slots_in_use = 1;
		else if (v > MAX_SLOTS)
			slots_in_use = MAX_SLOTS;
		else
			slots_in_use = v;
	endfunction

	// Expected response of one transaction; updates the shadow directory.
	function automatic reply_t lookup_directory(input request_t r);
		reply_t    o;
		bit [63:0] sc;
		bit [63:0] last;
		bit [63:0] addr;
		bit [63:0] blk;
		bit [63:0] s;
		bit [63:0] tg;
		bit [63:0] victim;
		int        f;
		int        si;
		o = '0;
		sc = 64'(slots_in_use);
		f = int'(r.file_id);
		if (r.func == FUNC_OPEN) begin
			if (seg_total >= MAX_SEGMENTS) begin
				o.status = ST_TOO_MANY;
			end else begin
				last = seg_end[seg_total] + 64'(r.seg_size);
				// tag of the new space's end address must fit the tag store
				if (((last >> BLOCK_BITS) / sc) > 64'(TAG_MAX)) begin
					o.status = ST_TOO_LARGE;
				end else begin
					seg_end[seg_total + 1] = last;
					o.handle = HANDLE_W'(seg_total);
					seg_total++;
				end
			end
		end else if (f >= int'(seg_total)) begin
			o.status = ST_BAD_HANDLE;
		end else begin
			addr = seg_end[f] + 64'(r.offset);
			if (addr >= seg_end[f + 1]) begin
				o.status = ST_OUT_OF_LIMITS;
			end else begin
				blk = addr >> BLOCK_BITS;
				s = blk % sc;
				tg = blk / sc;
				si = int'(s);
				// only reachable once the slot count has been lowered
				if (tg > 64'(TAG_MAX)) begin
					o.status = ST_TOO_LARGE;
				end else begin
					o.slot = s[SLOT_W-1:0];
					o.byte_offset = addr[BLOCK_BITS-1:0];
					// tags are read under the current count, no flush on change
					if (64'(tag_of[si]) != tg) begin
						if (dirty_of[si]) begin
							victim = 64'(tag_of[si]) * sc + s;
							o.writeback = 1'b1;
							o.writeback_block = victim[BLK_W-1:0];
						end
						o.fill = 1'b1;
						o.fill_block = blk[BLK_W-1:0];
						tag_of[si] = tg[TAG_W-1:0];
						dirty_of[si] = 1'b0;
					end
					if (r.write_mark)
						dirty_of[si] = 1'b1;
				end
			end
		end
		return o;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers. Fields a function ignores get random values so every
	// input bit toggles.
	// ------------------------------------------------------------------------
	function automatic request_t open_request(input logic [SEG_SIZE_W-1:0] size);
		request_t r;
		r.func = FUNC_OPEN;
		r.seg_size = size;
		r.file_id = FILE_W'($urandom_range(0, 31));
		r.offset = $urandom;
		r.write_mark = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic request_t find_request(input int unsigned f,
			input logic [OFFSET_W-1:0] off, input logic wr);
		request_t r;
		r.func = FUNC_FIND;
		r.seg_size = $urandom;
		r.file_id = FILE_W'(f);
		r.offset = off;
		r.write_mark = wr;
		return r;
	endfunction

	// Mostly small segments so that small slot counts can still take them;
	// full-range sizes exercise the space limit.
	function automatic logic [SEG_SIZE_W-1:0] pick_open_size();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return '0;
		else if (roll < 40)
			return $urandom_range(1, 4096);
		else if (roll < 70)
			return $urandom_range(4097, 262144);
		else if (roll < 85)
			return $urandom_range(262145, 4194304);
		return $urandom;
	endfunction

	// Finds: mostly inside an open segment, with re-use of recent addresses
	// for hits, conflicting blocks for write-backs, and some noise.
	function automatic request_t pick_find();
		request_t    r;
		byte_ref_t   ref_pick;
		bit [63:0]   size;
		bit [63:0]   off;
		bit [63:0]   alt;
		int unsigned roll;
		int unsigned f;
		bit          reuse;
		r = find_request($urandom_range(0, 31), $urandom, 1'($urandom_range(0, 1)));
		roll = $urandom_range(0, 99);
		if (seg_total == 0 || roll < 6)
			return r;
		reuse = roll < 45 && recent_finds.size() != 0;
		if (roll < 45 && !reuse)
			roll = $urandom_range(45, 99);
		off = '0;
		f = $urandom_range(0, seg_total - 1);
		if (reuse) begin
			ref_pick = recent_finds[$urandom_range(0, recent_finds.size() - 1)];
			f = ref_pick.file_id;
			off = 64'(ref_pick.offset);
		end
		size = seg_end[f + 1] - seg_end[f];
		if (reuse) begin
			if (roll < 15) begin
				// same slot, other tag
				alt = off + 64'(slots_in_use) * 64'(1 << BLOCK_BITS)
					* 64'($urandom_range(1, 3));
				if (alt < size)
					off = alt;
			end else if (roll < 25) begin
				// other byte of the same block
				alt = {off[63:BLOCK_BITS], BLOCK_BITS'($urandom)};
				if (alt < size)
					off = alt;
			end
		end else if (roll < 55) begin
			off = size;
		end else if (roll < 62) begin
			off = 64'($urandom);
		end else if (size != 0) begin
			off = {$urandom, $urandom} % size;
		end
		r.file_id = FILE_W'(f);
		r.offset = off[OFFSET_W-1:0];
		return r;
	endfunction

	function automatic int unsigned request_gap();
		if (steady_flow || $urandom_range(0, 99) >= 45)
			return 0;
		return $urandom_range(1, 40);
	endfunction

	// One request transaction: optional idle, then hold valid until the
	// block takes it. Called and returning at a rising edge, so valid is
	// never lowered and raised in the same step.
	task automatic send_item(input request_t r);
		int unsigned gap;
		reply_t      want;
		gap = request_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= r.func;
		req_ch.seg_size <= r.seg_size;
		req_ch.file_id <= r.file_id;
		req_ch.offset <= r.offset;
		req_ch.write_mark <= r.write_mark;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		want = lookup_directory(r);
		awaited_replies.push_back(want);
		if (r.func == FUNC_OPEN)
			n_opens++;
		else
			n_finds++;
		if (want.status != ST_OK)
			n_rejects++;
		if (want.fill)
			n_fills++;
		if (want.writeback)
			n_writebacks++;
		if (r.func == FUNC_FIND && want.status == ST_OK) begin
			recent_finds.push_back('{r.file_id, r.offset});
			if (recent_finds.size() > RECENT_DEPTH)
				void'(recent_finds.pop_front());
		end
	endtask

	// Slot count writes only with the block idle: every transaction yields
	// one response, so an empty queue plus a short guard is enough.
	task automatic write_slot_count(input logic [SC_W-1:0] v);
		req_ch.valid <= 1'b0;
		while (awaited_replies.size() != 0) @(posedge clk);
		repeat (CFG_GUARD) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_slot_count(v);
		n_cfg_writes++;
	endtask

	// Random mix; opens only while fewer than seg_cap segments are open.
	task automatic run_traffic(input int unsigned n_items, input int unsigned open_pct,
			input int unsigned seg_cap);
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 99) < open_pct && seg_total < seg_cap)
				send_item(open_request(pick_open_size()));
			else
				send_item(pick_find());
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset slot count (1024): bad handles, empty and one-byte segments,
	// segment bounds, hit on the cleared store, dirty victim write-back.
	task automatic test_basic_lookups();
		send_item(find_request(0, 32'h0, 1'b0));
		send_item(find_request(31, 32'hffff_ffff, 1'b1));
		send_item(open_request(32'h0));
		send_item(find_request(0, 32'h0, 1'b1));
		send_item(open_request(32'h1));
		// address 0, tag 0 is present after the clear: hit, now dirty
		send_item(find_request(1, 32'h0, 1'b1));
		send_item(find_request(1, 32'h1, 1'b0));
		send_item(open_request(32'h0010_0000));
		// block 1024 lands in slot 0 and evicts the dirty block 0
		send_item(find_request(2, 32'h0007_ffff, 1'b0));
		send_item(find_request(2, 32'h000f_fffe, 1'b0));
		send_item(find_request(2, 32'h000f_ffff, 1'b1));
		send_item(find_request(2, 32'hffff_ffff, 1'b0));
		send_item(find_request(3, 32'h0, 1'b0));
		send_item(open_request(32'd700));
		send_item(find_request(3, 32'd699, 1'b1));
		send_item(find_request(3, 32'd0, 1'b0));
		send_item(find_request(2, 32'h0007_ffff, 1'b1));
		send_item(find_request(2, 32'h0, 1'b0));
	endtask

	// Few slots: constant conflicts and write-backs. Zero is taken as one.
	task automatic test_small_slot_counts();
		write_slot_count(SC_W'(0));
		run_traffic(150, 6, 10);
		write_slot_count(SC_W'(3));
		run_traffic(150, 6, 10);
		write_slot_count(SC_W'(7));
		steady_flow = 1'b1;
		run_traffic(150, 6, 10);
		steady_flow = 1'b0;
	endtask

	// Values above the store size clamp to it; old tags now read under a
	// different count.
	task automatic test_slot_count_clamp();
		write_slot_count(SC_W'(2047));
		run_traffic(120, 0, 0);
		write_slot_count(SC_W'(1025));
		run_traffic(60, 0, 0);
	endtask

	// Space too large on open and on find, then table full.
	task automatic test_space_limits();
		int unsigned big;
		write_slot_count(SC_W'(MAX_SLOTS));
		repeat (4) send_item(open_request(32'hffff_ffff));
		big = seg_total - 1;
		send_item(find_request(big, 32'hffff_fffe, 1'b1));
		send_item(find_request(big, 32'h0, 1'b0));
		// one slot: high blocks of the large segment give tags past 15 bits
		write_slot_count(SC_W'(1));
		send_item(find_request(big, 32'hffff_fffe, 1'b0));
		send_item(find_request(big, 32'h8000_0000, 1'b1));
		send_item(find_request(1, 32'h0, 1'b1));
		send_item(open_request(32'd512));
		write_slot_count(SC_W'(MAX_SLOTS));
		while (seg_total < MAX_SEGMENTS)
			send_item(open_request(32'h0));
		send_item(open_request($urandom));
		send_item(find_request(MAX_SEGMENTS - 1, 32'h0, 1'b0));
		send_item(find_request(MAX_SEGMENTS, 32'h0, 1'b0));
	endtask

	// Random slot counts over the full register range, full table.
	task automatic test_random_slot_counts();
		for (int k = 0; k < 3; k++) begin
			write_slot_count(SC_W'($urandom_range(0, 2047)));
			run_traffic(120, 4, MAX_SEGMENTS + 1);
		end
	endtask

	// ------------------------------------------------------------------------
	// Response side: random backpressure, compare each transaction with the
	// oldest expectation.
	// ------------------------------------------------------------------------
	initial begin
		reply_t got;
		reply_t want;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.status = rsp_ch.status;
				got.handle = rsp_ch.handle;
				got.slot = rsp_ch.slot;
				got.byte_offset = rsp_ch.byte_offset;
				got.writeback = rsp_ch.writeback;
				got.writeback_block = rsp_ch.writeback_block;
				got.fill = rsp_ch.fill;
				got.fill_block = rsp_ch.fill_block;
				if (awaited_replies.size() == 0) begin
					report_error($sformatf("response %0h with none pending", got));
				end else begin
					want = awaited_replies.pop_front();
					if (got.status !== want.status)
						report_error($sformatf("resp %0d status %0h, want %0h",
							n_checked, got.status, want.status));
					if (got.handle !== want.handle)
						report_error($sformatf("resp %0d handle %0h, want %0h",
							n_checked, got.handle, want.handle));
					if (got.slot !== want.slot)
						report_error($sformatf("resp %0d slot %0h, want %0h",
							n_checked, got.slot, want.slot));
					if (got.byte_offset !== want.byte_offset)
						report_error($sformatf("resp %0d byte_offset %0h, want %0h",
							n_checked, got.byte_offset, want.byte_offset));
					if (got.writeback !== want.writeback)
						report_error($sformatf("resp %0d writeback %0h, want %0h",
							n_checked, got.writeback, want.writeback));
					if (got.writeback_block !== want.writeback_block)
						report_error($sformatf("resp %0d writeback_block %0h, want %0h",
							n_checked, got.writeback_block, want.writeback_block));
					if (got.fill !== want.fill)
						report_error($sformatf("resp %0d fill %0h, want %0h",
							n_checked, got.fill, want.fill));
					if (got.fill_block !== want.fill_block)
						report_error($sformatf("resp %0d fill_block %0h, want %0h",
							n_checked, got.fill_block, want.fill_block));
					n_checked++;
				end
			end
			rsp_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 24);
		end
	end

	// Watchdog: ends the run when neither channel moves for too long.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
					|| (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transaction for %0d cycles", quiet);
		$display("segmented_direct_mapped_block_cache_unit verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.func <= FUNC_OPEN;
		req_ch.seg_size <= '0;
		req_ch.file_id <= '0;
		req_ch.offset <= '0;
		req_ch.write_mark <= 1'b0;
		steady_flow = 1'b0;
		seg_total = 0;
		for (int i = 0; i <= MAX_SEGMENTS; i++)
			seg_end[i] = '0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			tag_of[i] = '0;
			dirty_of[i] = 1'b0;
		end
		slots_in_use = MAX_SLOTS;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// the block holds ready low through its clearing pass; the first
		// request simply waits for it
		test_basic_lookups();
		test_small_slot_counts();
		test_slot_count_clamp();
		test_space_limits();
		test_random_slot_counts();

		req_ch.valid <= 1'b0;
		while (awaited_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_replies.size() != 0)
			report_error($sformatf("%0d responses never arrived", awaited_replies.size()));

		$display("Ran %0d opens and %0d finds over %0d slot count settings; %0d rejected.",
			n_opens, n_finds, n_cfg_writes + 1, n_rejects);
		$display("Checked %0d responses: %0d misses, %0d dirty write-backs, %0d errors.",
			n_checked, n_fills, n_writebacks, n_errors);
		if (n_errors == 0)
			$display("segmented_direct_mapped_block_cache_unit verification clean");
		else
			$display("segmented_direct_mapped_block_cache_unit verification failed");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/sdmbc_pkg.sv
hw/rtl/sdmbc_if.sv
hw/rtl/sdmbc_div.sv
hw/rtl/sdmbc_seg_table.sv
hw/rtl/segmented_direct_mapped_block_cache_unit.sv
verif/segmented_direct_mapped_block_cache_unit_test.sv
